// ----- hdl/pls_pkg.sv -----
package pls_pkg;

	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 128;
	localparam int CRD_W    = $clog2(MAX_COLS);
	localparam int ADDR_W   = $clog2(MAX_COLS) + $clog2(MAX_ROWS);
	localparam int DEPTH    = MAX_COLS * MAX_ROWS;
	localparam int TAPS     = 21;
	localparam int STEP_W   = 5;

	// datapath widths
	localparam int MUL_W = 34;
	localparam int ACC_W = 67;
	localparam int MAG_W = 65;
	localparam int SC_W  = 98;
	localparam int RND_B = 46;

	localparam logic REQ_STORE   = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SAT   = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam logic [1:0] CFG_COLS  = 2'd0;
	localparam logic [1:0] CFG_ROWS  = 2'd1;
	localparam logic [1:0] CFG_SCALE = 2'd2;

	// Q4.30 stencil weights, sign included
	localparam logic signed [MUL_W-1:0] W_CENTRE = -34'sd4509715661;
	localparam logic signed [MUL_W-1:0] W_EDGE   =  34'sd930576247;
	localparam logic signed [MUL_W-1:0] W_DIAG   =  34'sd286331153;
	localparam logic signed [MUL_W-1:0] W_AXIS2  = -34'sd17895697;
	localparam logic signed [MUL_W-1:0] W_KNIGHT = -34'sd35791394;

	typedef struct packed {
		logic        req_type;
		logic [6:0]  col;
		logic [6:0]  row;
		logic [31:0] sample;
	} req_t;

	typedef struct packed {
		logic [31:0] laplacian;
		logic [1:0]  status;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TAP,
		S_DRAIN,
		S_SCL_LO,
		S_SCL_HI,
		S_FLUSH,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		MAC_NONE,
		MAC_TAP,
		MAC_SCL_LO,
		MAC_SCL_HI
	} mac_op_t;

	typedef struct packed {
		logic                     clr;
		mac_op_t                  op;
		logic signed [MUL_W-1:0]  w;
	} mac_ctl_t;

	typedef struct packed {
		logic signed [2:0]        dc;
		logic signed [2:0]        dr;
		logic signed [MUL_W-1:0]  w;
	} tap_t;

	function automatic tap_t tap_info(input logic [STEP_W-1:0] step);
		tap_t t;
		case (step)
			5'd0:    t = '{dc:  3'sd0, dr:  3'sd0, w: W_CENTRE};
			5'd1:    t = '{dc:  3'sd1, dr:  3'sd0, w: W_EDGE};
			5'd2:    t = '{dc: -3'sd1, dr:  3'sd0, w: W_EDGE};
			5'd3:    t = '{dc:  3'sd0, dr:  3'sd1, w: W_EDGE};
			5'd4:    t = '{dc:  3'sd0, dr: -3'sd1, w: W_EDGE};
			5'd5:    t = '{dc:  3'sd1, dr:  3'sd1, w: W_DIAG};
			5'd6:    t = '{dc: -3'sd1, dr:  3'sd1, w: W_DIAG};
			5'd7:    t = '{dc:  3'sd1, dr: -3'sd1, w: W_DIAG};
			5'd8:    t = '{dc: -3'sd1, dr: -3'sd1, w: W_DIAG};
			5'd9:    t = '{dc:  3'sd2, dr:  3'sd0, w: W_AXIS2};
			5'd10:   t = '{dc: -3'sd2, dr:  3'sd0, w: W_AXIS2};
			5'd11:   t = '{dc:  3'sd0, dr:  3'sd2, w: W_AXIS2};
			5'd12:   t = '{dc:  3'sd0, dr: -3'sd2, w: W_AXIS2};
			5'd13:   t = '{dc:  3'sd1, dr:  3'sd2, w: W_KNIGHT};
			5'd14:   t = '{dc: -3'sd1, dr:  3'sd2, w: W_KNIGHT};
			5'd15:   t = '{dc:  3'sd1, dr: -3'sd2, w: W_KNIGHT};
			5'd16:   t = '{dc: -3'sd1, dr: -3'sd2, w: W_KNIGHT};
			5'd17:   t = '{dc:  3'sd2, dr:  3'sd1, w: W_KNIGHT};
			5'd18:   t = '{dc: -3'sd2, dr:  3'sd1, w: W_KNIGHT};
			5'd19:   t = '{dc:  3'sd2, dr: -3'sd1, w: W_KNIGHT};
			5'd20:   t = '{dc: -3'sd2, dr: -3'sd1, w: W_KNIGHT};
			default: t = '{dc:  3'sd0, dr:  3'sd0, w: '0};
		endcase
		return t;
	endfunction

	// periodic wrap; coordinate < n, offset within +-2, so two corrections suffice
	function automatic logic [CRD_W-1:0] wrap_coord(
		input logic [CRD_W-1:0] c,
		input logic signed [2:0] d,
		input logic [7:0]        n
	);
		logic signed [9:0] v;
		logic signed [9:0] ns;
		ns = signed'({2'b00, n});
		v  = signed'({3'b000, c}) + 10'(d);
		if (v < 0)
			v = v + ns;
		if (v < 0)
			v = v + ns;
		if (v >= ns)
			v = v - ns;
		if (v >= ns)
			v = v - ns;
		return v[CRD_W-1:0];
	endfunction

endpackage

// ----- hdl/periodic_laplacian_stencil_top.sv -----
// Stores one periodic 2-D grid of signed Q16.16 samples in a memory with one write and
// one read port and evaluates the 21-point isotropic 5x5 Laplacian at a cell on request.
// A store request takes one transfer, and req_ready stays high after it. For a compute
// request the 21 neighbor reads go one per cycle through the single memory read port
// into one shared 34x34 multiplier and accumulator, and the same multiplier then
// applies scale_q in two partial products. An out-of-range compute skips the taps
// and returns status 2 with a zero laplacian. The block takes one request at a time;
// a finished result sits in an output register and waits there for res_ready. Every
// cell must be written before a stencil reads it.
module periodic_laplacian_stencil_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pls_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output pls_pkg::res_t res,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_wdata
);

	pls_pkg::state_t            state_q;
	pls_pkg::state_t            state_nxt;
	logic [pls_pkg::STEP_W-1:0] step_q;
	logic [pls_pkg::STEP_W-1:0] step_nxt;
	logic [pls_pkg::CRD_W-1:0]  col_q;
	logic [pls_pkg::CRD_W-1:0]  row_q;
	logic                       err_q;
	logic [7:0]                 cols_q;
	logic [7:0]                 rows_q;
	logic [31:0]                scale_q;
	logic [7:0]                 nc;
	logic [7:0]                 nr;
	logic                       in_range;
	logic                       req_xfer;
	logic                       start;
	logic                       res_ld;
	logic                       res_valid_q;
	pls_pkg::res_t              res_q;
	pls_pkg::res_t              mac_res;
	pls_pkg::tap_t              tap;
	pls_pkg::mac_ctl_t          ctl;
	logic                       rd_en;
	logic [pls_pkg::ADDR_W-1:0] rd_addr;
	logic [31:0]                rd_q;
	logic [31:0]                mem [pls_pkg::DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= 8'd128;
			rows_q  <= 8'd128;
			scale_q <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				pls_pkg::CFG_COLS:  cols_q  <= cfg_wdata[7:0];
				pls_pkg::CFG_ROWS:  rows_q  <= cfg_wdata[7:0];
				pls_pkg::CFG_SCALE: scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign nc = (cols_q > 8'(pls_pkg::MAX_COLS)) ? 8'(pls_pkg::MAX_COLS) : cols_q;
	assign nr = (rows_q > 8'(pls_pkg::MAX_ROWS)) ? 8'(pls_pkg::MAX_ROWS) : rows_q;
	assign in_range = ({1'b0, req.col} < nc) && ({1'b0, req.row} < nr);
	assign req_xfer = req_valid && req_ready;
	assign start    = req_xfer && (req.req_type == pls_pkg::REQ_COMPUTE);

	assign tap     = pls_pkg::tap_info(step_q);
	assign rd_addr = {pls_pkg::wrap_coord(row_q, tap.dr, nr),
	                  pls_pkg::wrap_coord(col_q, tap.dc, nc)};

	always_ff @(posedge clk) begin
		if (req_xfer && req.req_type == pls_pkg::REQ_STORE && in_range)
			mem[{req.row, req.col}] <= req.sample;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_comb begin
		state_nxt = state_q;
		step_nxt  = step_q;
		req_ready = 1'b0;
		rd_en     = 1'b0;
		res_ld    = 1'b0;
		ctl.clr   = 1'b0;
		ctl.op    = pls_pkg::MAC_NONE;
		ctl.w     = tap.w;
		case (state_q)
			pls_pkg::S_IDLE: begin
				req_ready = 1'b1;
				step_nxt  = '0;
				if (start) begin
					ctl.clr   = 1'b1;
					state_nxt = in_range ? pls_pkg::S_TAP : pls_pkg::S_DONE;
				end
			end
			pls_pkg::S_TAP: begin
				rd_en    = 1'b1;
				ctl.op   = pls_pkg::MAC_TAP;
				step_nxt = step_q + 1'b1;
				if (step_q == pls_pkg::STEP_W'(pls_pkg::TAPS - 1)) begin
					step_nxt  = '0;
					state_nxt = pls_pkg::S_DRAIN;
				end
			end
			// last product reaches the accumulator, then its magnitude register
			pls_pkg::S_DRAIN: begin
				step_nxt = step_q + 1'b1;
				if (step_q == pls_pkg::STEP_W'(1)) begin
					step_nxt  = '0;
					state_nxt = pls_pkg::S_SCL_LO;
				end
			end
			pls_pkg::S_SCL_LO: begin
				ctl.op    = pls_pkg::MAC_SCL_LO;
				state_nxt = pls_pkg::S_SCL_HI;
			end
			pls_pkg::S_SCL_HI: begin
				ctl.op    = pls_pkg::MAC_SCL_HI;
				state_nxt = pls_pkg::S_FLUSH;
			end
			pls_pkg::S_FLUSH: begin
				step_nxt = step_q + 1'b1;
				if (step_q == pls_pkg::STEP_W'(1)) begin
					step_nxt  = '0;
					state_nxt = pls_pkg::S_DONE;
				end
			end
			pls_pkg::S_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_ld    = 1'b1;
					state_nxt = pls_pkg::S_IDLE;
				end
			end
			default: state_nxt = pls_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pls_pkg::S_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			state_q <= state_nxt;
			step_q  <= step_nxt;
			if (start)
				err_q <= !in_range;
			if (res_ld)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			col_q <= req.col;
			row_q <= req.row;
		end
		if (res_ld) begin
			if (err_q) begin
				res_q.laplacian <= '0;
				res_q.status    <= pls_pkg::STAT_RANGE;
			end else begin
				res_q <= mac_res;
			end
		end
	end

	pls_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_data (rd_q),
		.scale   (scale_q),
		.result  (mac_res)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- hdl/pls_mac.sv -----
module pls_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  pls_pkg::mac_ctl_t ctl,
	input  logic [31:0]       rd_data,
	input  logic [31:0]       scale,
	output pls_pkg::res_t     result
);

	pls_pkg::mac_op_t                       op_s1;
	pls_pkg::mac_op_t                       op_s2;
	logic signed [pls_pkg::MUL_W-1:0]       w_s1;
	logic signed [pls_pkg::MUL_W-1:0]       mul_a;
	logic signed [pls_pkg::MUL_W-1:0]       mul_b;
	logic signed [2*pls_pkg::MUL_W-1:0]     prod;
	logic signed [2*pls_pkg::MUL_W-1:0]     prod_s2;
	logic signed [pls_pkg::ACC_W-1:0]       acc_q;
	logic signed [pls_pkg::ACC_W-1:0]       acc_abs;
	logic [pls_pkg::MAG_W-1:0]              mag_q;
	logic                                   neg_q;
	logic [pls_pkg::SC_W-1:0]               sc_q;
	logic [pls_pkg::SC_W-pls_pkg::RND_B-1:0] q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= pls_pkg::MAC_NONE;
			op_s2 <= pls_pkg::MAC_NONE;
		end else begin
			op_s1 <= ctl.op;
			op_s2 <= op_s1;
		end
	end

	// shared multiplier: stencil taps, then two partial products of the scaling
	always_comb begin
		case (op_s1)
			pls_pkg::MAC_TAP: begin
				mul_a = signed'({{2{rd_data[31]}}, rd_data});
				mul_b = w_s1;
			end
			pls_pkg::MAC_SCL_LO: begin
				mul_a = signed'({1'b0, mag_q[32:0]});
				mul_b = signed'({2'b00, scale});
			end
			pls_pkg::MAC_SCL_HI: begin
				mul_a = signed'({2'b00, mag_q[64:33]});
				mul_b = signed'({2'b00, scale});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign acc_abs = acc_q[pls_pkg::ACC_W-1] ? -acc_q : acc_q;

	always_ff @(posedge clk) begin
		w_s1    <= ctl.w;
		prod_s2 <= prod;
		mag_q   <= acc_abs[pls_pkg::MAG_W-1:0];
		neg_q   <= acc_q[pls_pkg::ACC_W-1];
		if (ctl.clr)
			acc_q <= '0;
		else if (op_s2 == pls_pkg::MAC_TAP)
			acc_q <= acc_q + prod_s2[pls_pkg::ACC_W-1:0];
		case (op_s2)
			// rounding half folded into the first partial product
			pls_pkg::MAC_SCL_LO:
				sc_q <= pls_pkg::SC_W'(prod_s2[pls_pkg::MAG_W-1:0])
					+ (pls_pkg::SC_W'(1) << (pls_pkg::RND_B - 1));
			pls_pkg::MAC_SCL_HI:
				sc_q <= sc_q + {prod_s2[pls_pkg::MAG_W-1:0], 33'b0};
			default: ;
		endcase
	end

	assign q = sc_q[pls_pkg::SC_W-1:pls_pkg::RND_B];

	always_comb begin
		if (!neg_q) begin
			if (q > 52'h0_7FFF_FFFF) begin
				result.laplacian = 32'h7FFF_FFFF;
				result.status    = pls_pkg::STAT_SAT;
			end else begin
				result.laplacian = q[31:0];
				result.status    = pls_pkg::STAT_OK;
			end
		end else begin
			if (q > 52'h0_8000_0000) begin
				result.laplacian = 32'h8000_0000;
				result.status    = pls_pkg::STAT_SAT;
			end else begin
				result.laplacian = 32'(0) - q[31:0];
				result.status    = pls_pkg::STAT_OK;
			end
		end
	end

endmodule

// ----- hdl/pls_checker.sv -----
module pls_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input pls_pkg::req_t req,
	input logic          res_valid,
	input logic          res_ready,
	input pls_pkg::res_t res
);

	// held result must not change while the sink stalls
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == pls_pkg::STAT_RANGE |-> res.laplacian == 32'd0)
		else $error("range error with nonzero value");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == pls_pkg::STAT_SAT
		|-> res.laplacian == 32'h7FFF_FFFF || res.laplacian == 32'h8000_0000)
		else $error("saturated result not at a bound");

	// ready must be low in the cycle after a compute transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == pls_pkg::REQ_COMPUTE |=> !req_ready)
		else $error("ready right after compute transfer");

endmodule

bind periodic_laplacian_stencil_top pls_checker u_pls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

// ----- dv/stencil_checker.sv -----
module stencil_checker
	import pls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_t        res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output int          mismatch_count,
	output int          lap_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Q4.30 ring weights, magnitudes only; signs are applied in the sum
	localparam logic signed [127:0] WT_CENTRE = 128'sd4509715661;
	localparam logic signed [127:0] WT_EDGE   = 128'sd930576247;
	localparam logic signed [127:0] WT_DIAG   = 128'sd286331153;
	localparam logic signed [127:0] WT_AXIS2  = 128'sd17895697;
	localparam logic signed [127:0] WT_KNIGHT = 128'sd35791394;

	logic [31:0] grid_mirror [DEPTH];
	logic [7:0]  cols_cfg;
	logic [7:0]  rows_cfg;
	logic [31:0] scale_cfg;
	res_t        lap_expected [$];
	res_t        want;
	int          fail_cnt;

	function automatic int eff_size(input logic [7:0] n, input int lim);
		return (n > lim) ? lim : int'(n);
	endfunction

	function automatic bit in_grid(input logic [6:0] c, input logic [6:0] r);
		return (c < eff_size(cols_cfg, MAX_COLS)) && (r < eff_size(rows_cfg, MAX_ROWS));
	endfunction

	function automatic res_t predict_laplacian(input logic [6:0] c, input logic [6:0] r);
		res_t                o;
		int                  nc, nr, x, y, d2;
		logic signed [31:0]  v;
		logic signed [127:0] s_centre, s_edge, s_diag, s_axis, s_knight, acc;
		logic [127:0]        mag, q;
		o.laplacian = '0;
		o.status    = STAT_RANGE;
		if (!in_grid(c, r))
			return o;
		nc = eff_size(cols_cfg, MAX_COLS);
		nr = eff_size(rows_cfg, MAX_ROWS);
		s_centre = '0;
		s_edge   = '0;
		s_diag   = '0;
		s_axis   = '0;
		s_knight = '0;
		// squared distance picks the ring; corners of the 5x5 are not taps
		for (int dr = -2; dr <= 2; dr++) begin
			for (int dc = -2; dc <= 2; dc++) begin
				x  = (int'(c) + dc + 2 * nc) % nc;
				y  = (int'(r) + dr + 2 * nr) % nr;
				v  = grid_mirror[y * MAX_COLS + x];
				d2 = dc * dc + dr * dr;
				case (d2)
					0: s_centre = s_centre + v;
					1: s_edge   = s_edge + v;
					2: s_diag   = s_diag + v;
					4: s_axis   = s_axis + v;
					5: s_knight = s_knight + v;
					default: ;
				endcase
			end
		end
		acc = s_edge * WT_EDGE + s_diag * WT_DIAG - s_centre * WT_CENTRE
			- s_axis * WT_AXIS2 - s_knight * WT_KNIGHT;
		mag = acc[127] ? -acc : acc;
		// 62 fraction bits down to 16, half away from zero
		q = (mag * {96'd0, scale_cfg} + (128'd1 << 45)) >> 46;
		o.status = STAT_OK;
		if (!acc[127]) begin
			if (q > 128'h7FFF_FFFF) begin
				o.laplacian = 32'h7FFF_FFFF;
				o.status    = STAT_SAT;
			end else begin
				o.laplacian = q[31:0];
			end
		end else begin
			if (q > 128'h8000_0000) begin
				o.laplacian = 32'h8000_0000;
				o.status    = STAT_SAT;
			end else begin
				o.laplacian = ~q[31:0] + 32'd1;
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg  = 8'd128;
			rows_cfg  = 8'd128;
			scale_cfg = 32'd65536;
			lap_expected.delete();
			fail_cnt = 0;
			mismatch_count <= 0;
			lap_pending    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COLS:  cols_cfg  = cfg_wdata[7:0];
					CFG_ROWS:  rows_cfg  = cfg_wdata[7:0];
					CFG_SCALE: scale_cfg = cfg_wdata;
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				if (req.req_type == REQ_COMPUTE)
					lap_expected.push_back(predict_laplacian(req.col, req.row));
				else if (in_grid(req.col, req.row))
					grid_mirror[int'(req.row) * MAX_COLS + int'(req.col)] = req.sample;
			end
			if (res_valid && res_ready) begin
				if (lap_expected.size() == 0) begin
					fail_cnt++;
					$display("%0t: result transfer with nothing outstanding: expected none, actual laplacian %h status %0d",
						$time, res.laplacian, res.status);
				end else begin
					want = lap_expected.pop_front();
					if (res.laplacian !== want.laplacian) begin
						fail_cnt++;
						$display("%0t: laplacian mismatch: expected %h actual %h",
							$time, want.laplacian, res.laplacian);
					end
					if (res.status !== want.status) begin
						fail_cnt++;
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, want.status, res.status);
					end
				end
			end
			mismatch_count <= fail_cnt;
			lap_pending    <= lap_expected.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pls_pkg::*;

	localparam int IDLE_PCT    = 36;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYC  = 40;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        res_valid;
	logic        res_ready;
	res_t        res;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;
	int          mismatch_count;
	int          lap_pending;

	int idle_pct;
	int eff_cols;
	int eff_rows;
	int items;
	int computes;
	bit written [DEPTH];

	periodic_laplacian_stencil_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	stencil_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.lap_pending    (lap_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= idle_pct);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (res_valid && res_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic logic [31:0] rand_sample();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return v;
			default: return {{12{v[19]}}, v[19:0]};
		endcase
	endfunction

	function automatic logic [31:0] rand_scale();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(4 * 65536, 1);
			2: return 32'd65536;
			default: return $urandom_range(255, 1);
		endcase
	endfunction

	// half the time a cell on or next to the wrap seam
	function automatic int pick_coord(input int n);
		int k;
		if ($urandom_range(1) == 0)
			return $urandom_range(n - 1);
		k = $urandom_range(3);
		if (k >= 2)
			k = n - 4 + k;
		return ((k % n) + n) % n;
	endfunction

	task automatic load_config(input logic [7:0] cols, input logic [7:0] rows,
		input logic [31:0] scale);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_COLS;
		cfg_wdata <= {24'd0, cols};
		@(posedge clk);
		cfg_index <= CFG_ROWS;
		cfg_wdata <= {24'd0, rows};
		@(posedge clk);
		cfg_index <= CFG_SCALE;
		cfg_wdata <= scale;
		@(posedge clk);
		cfg_we <= 1'b0;
		eff_cols = (cols > MAX_COLS) ? MAX_COLS : int'(cols);
		eff_rows = (rows > MAX_ROWS) ? MAX_ROWS : int'(rows);
	endtask

	// valid only drops when a gap is taken, so back-to-back transfers keep it high
	task automatic send_req(input req_t item);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (lap_pending != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic store_cell(input int c, input int r, input logic [31:0] s);
		req_t item;
		item.req_type = REQ_STORE;
		item.col      = 7'(c);
		item.row      = 7'(r);
		item.sample   = s;
		send_req(item);
		if (c < eff_cols && r < eff_rows) begin
			written[r * MAX_COLS + c] = 1'b1;
			items++;
		end
	endtask

	task automatic compute_at(input int c, input int r, input logic [31:0] s);
		req_t item;
		item.req_type = REQ_COMPUTE;
		item.col      = 7'(c);
		item.row      = 7'(r);
		item.sample   = s;
		send_req(item);
		items++;
		computes++;
	endtask

	// write any tap cell not yet holding data, then ask for the stencil
	task automatic fill_and_compute(input int c, input int r);
		int x, y;
		for (int dr = -2; dr <= 2; dr++) begin
			for (int dc = -2; dc <= 2; dc++) begin
				if (dc * dc + dr * dr <= 5) begin
					x = (c + dc + 2 * eff_cols) % eff_cols;
					y = (r + dr + 2 * eff_rows) % eff_rows;
					if (!written[y * MAX_COLS + x])
						store_cell(x, y, rand_sample());
				end
			end
		end
		compute_at(c, r, $urandom());
	endtask

	task automatic any_item();
		int c, r;
		c = $urandom_range(127);
		r = $urandom_range(127);
		if ($urandom_range(1) == 0)
			store_cell(c, r, rand_sample());
		else if (c < eff_cols && r < eff_rows)
			fill_and_compute(c, r);
		else
			compute_at(c, r, $urandom());
	endtask

	task automatic off_grid_compute();
		if (eff_cols < MAX_COLS)
			compute_at($urandom_range(127, eff_cols), $urandom_range(127), $urandom());
		else if (eff_rows < MAX_ROWS)
			compute_at($urandom_range(127), $urandom_range(127, eff_rows), $urandom());
		else
			any_item();
	endtask

	task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows,
		input logic [31:0] scale, input int idle);
		int pick, item_goal, comp_goal;
		load_config(cols, rows, scale);
		idle_pct  = idle;
		item_goal = items + 100;
		comp_goal = computes + 20;
		while (items < item_goal || computes < comp_goal) begin
			pick = $urandom_range(99);
			if (eff_cols > 0 && eff_rows > 0 && pick < 55)
				fill_and_compute(pick_coord(eff_cols), pick_coord(eff_rows));
			else if (eff_cols > 0 && eff_rows > 0 && pick < 72)
				store_cell($urandom_range(eff_cols - 1), $urandom_range(eff_rows - 1),
					rand_sample());
			else if (pick < 90)
				any_item();
			else
				off_grid_compute();
		end
		settle();
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		res_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_COLS;
		cfg_wdata = '0;
		idle_pct  = IDLE_PCT;
		eff_cols  = MAX_COLS;
		eff_rows  = MAX_ROWS;
		items     = 0;
		computes  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 4x4 grid, every cell written with a rail value
		load_config(8'd4, 8'd4, 32'd65536);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				store_cell(c, r, (c == 1 && r == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
		compute_at(1, 1, 32'hFFFF_FFFF);
		compute_at(3, 3, 32'h0000_0000);
		compute_at(4, 0, 32'h5A5A_5A5A);
		compute_at(0, 4, 32'h0000_0000);
		compute_at(127, 127, 32'hFFFF_FFFF);
		store_cell(127, 127, 32'h1234_5678);
		store_cell(2, 2, 32'h0000_0000);
		compute_at(2, 2, 32'h0000_0000);
		compute_at(0, 0, 32'h0000_0000);
		settle();

		run_phase(8'd128, 8'd128, 32'd65536, IDLE_PCT);
		run_phase(8'd4, 8'd4, rand_scale(), IDLE_PCT);
		run_phase(8'd200, 8'd7, 32'hFFFF_FFFF, IDLE_PCT);
		run_phase(8'd1, 8'd1, 32'd65536, IDLE_PCT);
		run_phase(8'd2, 8'd3, 32'd1, 0);
		run_phase(8'd128, 8'd5, 32'd0, IDLE_PCT);
		run_phase(8'd0, 8'd16, 32'd65536, IDLE_PCT);
		run_phase(8'd255, 8'd255, rand_scale(), IDLE_PCT);
		run_phase(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)), rand_scale(),
			IDLE_PCT);
		run_phase(8'd9, 8'd128, 32'h0000_0400, 0);
		run_phase(8'd128, 8'd4, rand_scale(), IDLE_PCT);

		if (mismatch_count == 0 && lap_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/pls_pkg.sv
hdl/pls_mac.sv
hdl/periodic_laplacian_stencil_top.sv
hdl/pls_checker.sv
dv/stencil_checker.sv
dv/testbench.sv
